// ===== rtl/core/lz77wd_pkg.sv =====
package lz77wd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int SIZE_BITS    = 24;
  localparam int COUNT_W      = 25;
  localparam int DIST_W       = 13;
  localparam int LEN_W        = 5;

  localparam logic [23:0]        SIZE_MASK = 24'((32'd1 << SIZE_BITS) - 32'd1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_ENDED     = 3'd2;
  localparam logic [2:0] ST_DIST      = 3'd3;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd4;

  // commands from the parser to the copy engine
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_LIT  = 2'd1;
  localparam logic [1:0] CMD_ERR  = 2'd2;
  localparam logic [1:0] CMD_COPY = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_end;
    logic        final_byte;
    logic [2:0]  status;
    logic [24:0] consumed_size;
    logic [23:0] total_size;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         lit;
    logic [2:0]         status;
    logic [DIST_W-1:0]  match_dist;
    logic [LEN_W-1:0]   len;
    logic               final_run;
    logic [COUNT_W-1:0] consumed;
    logic [23:0]        total;
  } cmd_t;

endpackage

// ===== rtl/core/lz77wd_copy.sv =====
module lz77wd_copy (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  lz77wd_pkg::cmd_t      cmd,
  output logic                  cmd_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lz77wd_pkg::out_item_t out_data
);
  import lz77wd_pkg::*;

  localparam int SUM_W = ADDR_W + 1;

  logic [7:0] window_mem [WINDOW_DEPTH];
  logic [7:0] mem_q_r;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic               busy_r, busy_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               fwd_r, fwd_nxt;
  logic [7:0]         fwd_data_r, fwd_data_nxt;
  logic [ADDR_W-1:0]  wp_r, wp_nxt;
  logic [ADDR_W-1:0]  src_r, src_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic               final_r, final_nxt;
  logic [COUNT_W-1:0] consumed_r, consumed_nxt;
  logic [23:0]        total_r, total_nxt;

  logic              out_free, emit, last_b;
  logic [7:0]        copy_byte;
  logic [SUM_W-1:0]  src_full;
  logic [ADDR_W-1:0] src_first;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = !busy_r && out_free;
  assign emit      = busy_r && rd_pend_r && out_free;
  assign copy_byte = fwd_r ? fwd_data_r : mem_q_r;
  assign last_b    = (remain_r == LEN_W'(1));
  assign src_full  = {1'b0, wp_r} - SUM_W'(cmd.match_dist);
  assign src_first = src_full[ADDR_W-1:0];

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    we            = 1'b0;
    re            = 1'b0;
    waddr         = wp_r;
    raddr         = src_r;
    wdata         = cmd.lit;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_item_nxt  = out_item_r;
    busy_nxt      = busy_r;
    rd_pend_nxt   = rd_pend_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    remain_nxt    = remain_r;
    final_nxt     = final_r;
    consumed_nxt  = consumed_r;
    total_nxt     = total_r;
    if (cmd_valid) begin
      case (cmd.kind)
        CMD_LIT: begin
          we            = 1'b1;
          wp_nxt        = wp_r + ADDR_W'(1);
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{out_byte: cmd.lit, run_end: 1'b1, final_byte: cmd.final_run,
                            status: ST_OK, consumed_size: cmd.consumed,
                            total_size: cmd.total};
        end
        CMD_ERR: begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{out_byte: 8'h00, run_end: 1'b1, final_byte: 1'b0,
                            status: cmd.status, consumed_size: '0, total_size: '0};
        end
        CMD_COPY: begin
          re           = 1'b1;
          raddr        = src_first;
          src_nxt      = src_first + ADDR_W'(1);
          remain_nxt   = cmd.len;
          busy_nxt     = 1'b1;
          rd_pend_nxt  = 1'b1;
          fwd_nxt      = 1'b0;
          final_nxt    = cmd.final_run;
          consumed_nxt = cmd.consumed;
          total_nxt    = cmd.total;
        end
        default: ;
      endcase
    end else if (emit) begin
      we            = 1'b1;
      wdata         = copy_byte;
      wp_nxt        = wp_r + ADDR_W'(1);
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{out_byte: copy_byte, run_end: last_b,
                        final_byte: last_b && final_r, status: ST_OK,
                        consumed_size: (last_b && final_r) ? consumed_r : '0,
                        total_size: (last_b && final_r) ? total_r : '0};
      remain_nxt    = remain_r - LEN_W'(1);
      if (!last_b) begin
        re           = 1'b1;
        src_nxt      = src_r + ADDR_W'(1);
        // the byte being written now is the one the next read wants
        fwd_nxt      = (src_r == wp_r);
        fwd_data_nxt = copy_byte;
      end else begin
        busy_nxt    = 1'b0;
        rd_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      window_mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= window_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      wp_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      rd_pend_r   <= rd_pend_nxt;
      fwd_r       <= fwd_nxt;
      wp_r        <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    fwd_data_r <= fwd_data_nxt;
    src_r      <= src_nxt;
    remain_r   <= remain_nxt;
    final_r    <= final_nxt;
    consumed_r <= consumed_nxt;
    total_r    <= total_nxt;
  end

  a_busy_remain: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (remain_r != '0) && rd_pend_r)
    else $error("copy active with nothing left to emit");

  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last_b |=> !busy_r && out_valid_r && out_item_r.run_end)
    else $error("copy did not close on its last byte");

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && (cmd.kind == CMD_LIT || cmd.kind == CMD_ERR) |=> out_valid_r)
    else $error("single-result command produced no item");

  a_final_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.final_byte |-> out_item_r.run_end)
    else $error("final byte not marked as end of run");

endmodule

// ===== rtl/core/lz77_window_decompressor.sv =====
// LZ77 type-1 stream decoder with a 4096-byte history window. Compressed bytes enter one
// per item; each item yields zero or more decoded bytes, the last of them flagged run_end.
// Header and flag bytes, and match first bytes, give no result; a literal gives one byte; the
// second byte of a match gives len bytes (1..18 bytes after clipping), paced by the single read
// port of the window memory, which delivers one history byte per cycle while the output is not
// stalled, after a registered read ahead. Errors come out
// as one item with a nonzero status. After the final byte or an error the block ignores
// items until one with in_last arrives; padding after the stream must be dropped by the user.
module lz77_window_decompressor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lz77wd_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lz77wd_pkg::out_item_t out_data
);
  import lz77wd_pkg::*;

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_HDR2  = 3'd2;
  localparam logic [2:0] PH_HDR3  = 3'd3;
  localparam logic [2:0] PH_BODY  = 3'd4;
  localparam logic [2:0] PH_MATCH = 3'd5;
  localparam logic [2:0] PH_IDLE  = 3'd6;

  logic [2:0]         phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [23:0]        target_r, target_nxt;
  logic [23:0]        produced_r, produced_nxt;
  logic [7:0]         flag_bits_r, flag_bits_nxt;
  logic [3:0]         flag_idx_r, flag_idx_nxt;
  logic [7:0]         held_r, held_nxt;

  logic               acc, cmd_ready, rearm, err, tok, fin;
  logic [2:0]         err_code;
  cmd_t               cmd;
  logic [7:0]         b;
  logic [23:0]        left, tgt3;
  logic [DIST_W-1:0]  match_dist;
  logic [LEN_W-1:0]   mlen, len_c;
  logic               match_fin;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W:0]   cnt_plus;

  assign in_ready   = cmd_ready;
  assign acc        = in_valid && in_ready;
  assign b          = in_data.in_byte;
  assign left       = target_r - produced_r;
  assign match_dist = DIST_W'({held_r[3:0], b}) + DIST_W'(1);
  assign mlen       = LEN_W'(held_r[7:4]) + LEN_W'(3);
  assign tgt3       = {b, target_r[15:0]} & SIZE_MASK;
  assign match_fin  = (24'(mlen) >= left);
  assign len_c      = match_fin ? left[LEN_W-1:0] : mlen;
  // saturate the input count at its maximum
  assign count_inc  = (count_r != COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
  assign cnt_plus   = {1'b0, count_inc} + (COUNT_W+1)'(3);

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    target_nxt    = target_r;
    produced_nxt  = produced_r;
    flag_bits_nxt = flag_bits_r;
    flag_idx_nxt  = flag_idx_r;
    held_nxt      = held_r;
    cmd           = '0;
    cmd.kind      = CMD_NONE;
    rearm         = 1'b0;
    err           = 1'b0;
    err_code      = ST_OK;
    tok           = 1'b0;
    fin           = 1'b0;
    if (acc) begin
      if (phase_r == PH_IDLE) begin
        rearm = in_data.in_last;
      end else begin
        count_nxt = count_inc;
        case (phase_r)
          PH_HDR0: begin
            if (b[7:4] != 4'h1) begin
              err      = 1'b1;
              err_code = ST_BAD_TYPE;
            end else begin
              phase_nxt = PH_HDR1;
            end
          end
          PH_HDR1: begin
            target_nxt = {16'h0000, b};
            phase_nxt  = PH_HDR2;
          end
          PH_HDR2: begin
            target_nxt = {8'h00, b, target_r[7:0]};
            phase_nxt  = PH_HDR3;
          end
          PH_HDR3: begin
            target_nxt = tgt3;
            if (tgt3 == '0) begin
              err      = 1'b1;
              err_code = ST_ZERO_SIZE;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            if (flag_idx_r[3]) begin
              flag_bits_nxt = b;
              flag_idx_nxt  = '0;
            end else if (flag_bits_r[7]) begin
              held_nxt  = b;
              phase_nxt = PH_MATCH;
            end else begin
              tok           = 1'b1;
              fin           = (left == 24'd1);
              produced_nxt  = produced_r + 24'd1;
              cmd.kind      = CMD_LIT;
              cmd.lit       = b;
              flag_bits_nxt = {flag_bits_r[6:0], 1'b0};
              flag_idx_nxt  = flag_idx_r + 4'd1;
            end
          end
          PH_MATCH: begin
            phase_nxt = PH_BODY;
            if (24'(match_dist) > produced_r) begin
              err      = 1'b1;
              err_code = ST_DIST;
            end else begin
              tok            = 1'b1;
              fin            = match_fin;
              produced_nxt   = produced_r + 24'(len_c);
              cmd.kind       = CMD_COPY;
              cmd.match_dist = match_dist;
              cmd.len        = len_c;
              flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
              flag_idx_nxt   = flag_idx_r + 4'd1;
            end
          end
          default: ;
        endcase

        if (err) begin
          cmd        = '0;
          cmd.kind   = CMD_ERR;
          cmd.status = err_code;
          if (in_data.in_last) begin
            rearm = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else if (tok && fin) begin
          cmd.final_run = 1'b1;
          cmd.consumed  = {cnt_plus[COUNT_W-1:2], 2'b00};
          cmd.total     = target_r;
          if (in_data.in_last) begin
            rearm = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else if (in_data.in_last) begin
          // drop whatever this item decoded and report the early end
          cmd        = '0;
          cmd.kind   = CMD_ERR;
          cmd.status = ST_ENDED;
          rearm      = 1'b1;
        end
      end

      if (rearm) begin
        phase_nxt     = PH_HDR0;
        count_nxt     = '0;
        target_nxt    = '0;
        produced_nxt  = '0;
        flag_bits_nxt = '0;
        flag_idx_nxt  = 4'd8;
        held_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      count_r     <= '0;
      target_r    <= '0;
      produced_r  <= '0;
      flag_bits_r <= '0;
      flag_idx_r  <= 4'd8;
      held_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      target_r    <= target_nxt;
      produced_r  <= produced_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_idx_r  <= flag_idx_nxt;
      held_r      <= held_nxt;
    end
  end

  lz77wd_copy u_copy (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (acc),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lz77wd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 100;
  localparam logic [3:0] HDR_TYPE = 4'h1;

  typedef enum logic [2:0] {
    P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_BODY, P_MATCH, P_IDLE
  } parse_phase_e;

  class stream_scoreboard;
    logic [7:0]         window [WINDOW_DEPTH];
    logic [ADDR_W-1:0]  wr_ptr;
    logic [23:0]        produced;
    logic [23:0]        target;
    logic [COUNT_W-1:0] taken;
    logic [7:0]         flags;
    logic [3:0]         flag_idx;
    parse_phase_e       phase;
    logic [7:0]         held;
    out_item_t          step_q [$];
    out_item_t          due_bytes [$];

    function new();
      foreach (window[i]) window[i] = 8'h00;
      rearm();
    endfunction

    function void rearm();
      wr_ptr = '0;
      produced = '0;
      target = '0;
      taken = '0;
      flags = '0;
      flag_idx = 4'd8;
      phase = P_HDR0;
      held = '0;
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction

    function void emit(logic [7:0] b);
      window[wr_ptr] = b;
      wr_ptr++;
      produced = (produced + 24'd1) & SIZE_MASK;
      step_q.push_back('{out_byte: b, run_end: 1'b0, final_byte: 1'b0, status: ST_OK,
                         consumed_size: '0, total_size: '0});
    endfunction

    function void next_flag();
      flags = flags << 1;
      flag_idx++;
    endfunction

    // drop whatever this byte decoded and queue the single error item
    function void fail_stream(logic [2:0] code, logic last);
      due_bytes.push_back('{out_byte: 8'h00, run_end: 1'b1, final_byte: 1'b0, status: code,
                            consumed_size: '0, total_size: '0});
      if (last) rearm();
      else phase = P_IDLE;
    endfunction

    function void flush();
      foreach (step_q[i]) due_bytes.push_back(step_q[i]);
    endfunction

    function void take_byte(in_item_t it);
      logic [7:0]        b;
      logic              last;
      logic              token;
      logic [4:0]        len;
      logic [12:0]       match_dist;
      logic [23:0]       left;
      logic [ADDR_W-1:0] src;
      logic [25:0]       rounded;
      out_item_t         r;
      int                n;
      b = it.in_byte;
      last = it.in_last;
      token = 1'b0;
      step_q.delete();
      if (phase == P_IDLE) begin
        if (last) rearm();
        return;
      end
      if (taken != COUNT_MAX) taken++;
      case (phase)
        P_HDR0: begin
          if (b[7:4] != HDR_TYPE) begin
            fail_stream(ST_BAD_TYPE, last);
            return;
          end
          phase = P_HDR1;
        end
        P_HDR1: begin
          target = {16'h0000, b};
          phase = P_HDR2;
        end
        P_HDR2: begin
          target[15:8] = b;
          phase = P_HDR3;
        end
        P_HDR3: begin
          target[23:16] = b;
          target = target & SIZE_MASK;
          if (target == '0) begin
            fail_stream(ST_ZERO_SIZE, last);
            return;
          end
          phase = P_BODY;
        end
        P_BODY: begin
          if (flag_idx >= 4'd8) begin
            flags = b;
            flag_idx = 4'd0;
          end else if (flags[7]) begin
            held = b;
            phase = P_MATCH;
          end else begin
            emit(b);
            next_flag();
            token = 1'b1;
          end
        end
        default: begin
          len = {1'b0, held[7:4]} + 5'd3;
          match_dist = {1'b0, held[3:0], b} + 13'd1;
          phase = P_BODY;
          if (match_dist > produced) begin
            fail_stream(ST_DIST, last);
            return;
          end
          left = target - produced;
          if (len > left) len = 5'(left);
          for (int i = 0; i < len; i++) begin
            src = wr_ptr - match_dist[ADDR_W-1:0];
            emit(window[src]);
          end
          next_flag();
          token = 1'b1;
        end
      endcase
      n = step_q.size();
      if (token && produced == target && n > 0) begin
        rounded = {1'b0, taken} + 26'd3;
        r = step_q[n-1];
        r.run_end = 1'b1;
        r.final_byte = 1'b1;
        r.consumed_size = COUNT_W'(rounded & ~26'd3);
        r.total_size = target;
        step_q[n-1] = r;
        flush();
        if (last) rearm();
        else phase = P_IDLE;
        return;
      end
      if (last) begin
        fail_stream(ST_ENDED, 1'b1);
        return;
      end
      if (n > 0) begin
        r = step_q[n-1];
        r.run_end = 1'b1;
        step_q[n-1] = r;
      end
      flush();
    endfunction

    function string match_result(out_item_t got);
      out_item_t want;
      string     msg;
      if (due_bytes.size() == 0)
        return $sformatf(" item with nothing due: byte %h status %0d", got.out_byte, got.status);
      want = due_bytes.pop_front();
      msg = "";
      // out_byte carries no meaning on an error item
      if (want.status == ST_OK && got.out_byte !== want.out_byte)
        msg = {msg, $sformatf(" out_byte %h want %h", got.out_byte, want.out_byte)};
      if (got.run_end !== want.run_end)
        msg = {msg, $sformatf(" run_end %b want %b", got.run_end, want.run_end)};
      if (got.final_byte !== want.final_byte)
        msg = {msg, $sformatf(" final_byte %b want %b", got.final_byte, want.final_byte)};
      if (got.status !== want.status)
        msg = {msg, $sformatf(" status %0d want %0d", got.status, want.status)};
      if (got.consumed_size !== want.consumed_size)
        msg = {msg, $sformatf(" consumed_size %0d want %0d", got.consumed_size,
                              want.consumed_size)};
      if (got.total_size !== want.total_size)
        msg = {msg, $sformatf(" total_size %0d want %0d", got.total_size, want.total_size)};
      return msg;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int cycles;
  int live_items;

  stream_scoreboard sb;
  in_item_t         seq_q [$];

  lz77_window_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic report(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d:%s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    string msg;
    cycles++;
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_byte(in_data);
      if (out_valid && out_ready) begin
        msg = sb.match_result(out_data);
        if (msg != "") report(msg);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("lz77_window_decompressor test failed");
      $finish;
    end
  end

  // valid stays up between items unless the sender idles
  task automatic push_byte(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_seq();
    foreach (seq_q[i]) begin
      push_byte(seq_q[i]);
      live_items++;
    end
    seq_q.delete();
  endtask

  // let the last accepted item reach the scoreboard before counting what is due
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic void add(input logic [7:0] b, input logic last);
    seq_q.push_back('{in_byte: b, in_last: last});
  endfunction

  function automatic void set_last(input logic last);
    in_item_t it;
    it = seq_q[seq_q.size()-1];
    it.in_last = last;
    seq_q[seq_q.size()-1] = it;
  endfunction

  function automatic void add_header(input logic [23:0] size);
    add({HDR_TYPE, 4'($urandom_range(15))}, 1'b0);
    add(size[7:0], 1'b0);
    add(size[15:8], 1'b0);
    add(size[23:16], 1'b0);
  endfunction

  // a bad_tok of zero or more places a match that reaches before the start and ends the body
  function automatic void add_body(input int size, input int max_tokens, input int match_pct,
                                   input bit long_runs, input int bad_tok);
    int          made;
    int          tokens;
    int          flag_at;
    int          limit;
    int          span;
    int          d;
    int          k;
    logic [7:0]  flag_val;
    logic [3:0]  len_f;
    logic [11:0] dist_m1;
    made = 0;
    tokens = 0;
    while (made < size && tokens < max_tokens) begin
      flag_at = seq_q.size();
      flag_val = 8'($urandom_range(255));
      add(8'h00, 1'b0);
      for (k = 0; k < 8 && made < size && tokens < max_tokens; k++) begin
        if (tokens == bad_tok) begin
          flag_val[7-k] = 1'b1;
          d = $urandom_range(WINDOW_DEPTH, made + 1);
          dist_m1 = 12'(d - 1);
          len_f = 4'($urandom_range(15));
          add({len_f, dist_m1[11:8]}, 1'b0);
          add(dist_m1[7:0], 1'b0);
          seq_q[flag_at] = '{in_byte: flag_val, in_last: 1'b0};
          return;
        end
        if (made > 0 && $urandom_range(99) < match_pct) begin
          flag_val[7-k] = 1'b1;
          limit = (made < WINDOW_DEPTH) ? made : WINDOW_DEPTH;
          case ($urandom_range(3))
            0: d = 1;
            1: d = limit;
            default: d = $urandom_range(limit, 1);
          endcase
          len_f = (long_runs && $urandom_range(3) != 0) ? 4'hF : 4'($urandom_range(15));
          dist_m1 = 12'(d - 1);
          add({len_f, dist_m1[11:8]}, 1'b0);
          add(dist_m1[7:0], 1'b0);
          span = len_f + 3;
          made += (span < size - made) ? span : size - made;
        end else begin
          flag_val[7-k] = 1'b0;
          add(8'($urandom_range(255)), 1'b0);
          made++;
        end
        tokens++;
      end
      seq_q[flag_at] = '{in_byte: flag_val, in_last: 1'b0};
    end
  endfunction

  // the block ignores items until one with in_last re-arms it
  task automatic rearm_pad();
    repeat ($urandom_range(3)) add(8'($urandom_range(255)), 1'b0);
    add(8'($urandom_range(255)), 1'b1);
    send_seq();
  endtask

  task automatic run_random_seq();
    int   pick;
    int   size;
    int   cut;
    logic last;
    bit   idle_after;
    pick = $urandom_range(99);
    last = 1'($urandom_range(1));
    idle_after = 1'b0;
    size = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
    if (pick < 62) begin
      add_header(24'(size));
      add_body(size, 1 << 30, 50, 1'b0, -1);
      set_last(last);
      idle_after = !last;
    end else if (pick < 74) begin
      // stream cut short by in_last
      add_header(24'(size));
      add_body(size, 1 << 30, 50, 1'b0, -1);
      cut = $urandom_range(seq_q.size() - 2, 0);
      while (seq_q.size() > cut + 1) void'(seq_q.pop_back());
      set_last(1'b1);
    end else if (pick < 84) begin
      add_header(24'd200);
      add_body(200, 1 << 30, 50, 1'b0, $urandom_range(5));
      set_last(last);
      idle_after = !last;
    end else if (pick < 90) begin
      add({HDR_TYPE ^ 4'($urandom_range(15, 1)), 4'($urandom_range(15))}, last);
      idle_after = !last;
    end else if (pick < 95) begin
      add_header(24'd0);
      set_last(last);
      idle_after = !last;
    end else begin
      // huge size, input runs out long before the end
      add_header(24'($urandom_range(32'hFFFFFF, 32'h800000)));
      add_body(1 << 24, $urandom_range(12, 1), 50, 1'b0, -1);
      set_last(1'b1);
    end
    send_seq();
    if (idle_after) rearm_pad();
  endtask

  initial begin
    logic last;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    cycles = 0;
    live_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // bad type without in_last, then ignored bytes until one with in_last
    add(8'h20, 1'b0); add({HDR_TYPE, 4'h0}, 1'b0); add(8'hFF, 1'b1);
    // bad type with in_last re-arms at once
    add(8'h0F, 1'b1);
    // zero size wins over end of input
    add(8'h1F, 1'b0); add(8'h00, 1'b0); add(8'h00, 1'b0); add(8'h00, 1'b1);
    // two literals, then a long match clipped to the three bytes still due
    add(8'h10, 1'b0); add(8'h05, 1'b0); add(8'h00, 1'b0); add(8'h00, 1'b0);
    add(8'h20, 1'b0); add(8'h00, 1'b0); add(8'hFF, 1'b0); add(8'hF0, 1'b0); add(8'h00, 1'b1);
    // longest distance, too far even though the match would be clipped
    add(8'h10, 1'b0); add(8'h02, 1'b0); add(8'h00, 1'b0); add(8'h00, 1'b0);
    add(8'h40, 1'b0); add(8'h55, 1'b0); add(8'hFF, 1'b0); add(8'hFF, 1'b0); add(8'h00, 1'b1);
    send_seq();

    send_idle_pct = 27;
    recv_idle_pct = 52;
    while (live_items < 110) run_random_seq();
    pause_until_drained();

    send_idle_pct = 52;
    recv_idle_pct = 27;
    while (live_items < 220) run_random_seq();
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // one long stream made mostly of long matches
    last = 1'($urandom_range(1));
    add_header(24'd800);
    add_body(800, 1 << 30, 90, 1'b1, -1);
    set_last(last);
    send_seq();
    if (!last) rearm_pad();
    while (live_items < 330) run_random_seq();

    pause_until_drained();
    if (sb.pending() != 0) report($sformatf(" %0d results never arrived", sb.pending()));
    if (mismatches == 0) $display("lz77_window_decompressor test passed");
    else $display("lz77_window_decompressor test failed");
    $finish;
  end

endmodule

// ===== lz77_window_decompressor.f =====
rtl/core/lz77wd_pkg.sv
rtl/core/lz77wd_copy.sv
rtl/core/lz77_window_decompressor.sv
bench/testbench.sv
